// File: sv/crc32fac_pkg.sv
// Package for the CRC-32 frame append and check core.
// Holds the queue entry type, the result kind codes and the byte-wise CRC update.
// Depends on nothing.
package crc32fac_pkg;

    localparam logic [31:0] CRC_POLY         = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES         = 32'hFFFF_FFFF;
    localparam int          FIFO_DEPTH_DEF   = 4;
    localparam logic [2:0]  HELD_FULL        = 3'd4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_CRC     = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CMD_PAYLOAD     = 2'd0,
        CMD_PAY_APPEND  = 2'd1,
        CMD_PAY_VERDICT = 2'd2,
        CMD_VERDICT     = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  data;
        logic [31:0] crc;
        logic        ok;
        logic        short_frame;
    } entry_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: sv/crc32fac_front.sv
// Front end: takes input beats, keeps the running CRC, the delay line and the mode,
// and turns each beat into at most one queue entry. Depends on crc32fac_pkg.
module crc32fac_front import crc32fac_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    input  logic       push_ready,
    output logic       push_valid,
    output entry_t     push_entry
);

    logic        mode_reg;
    logic [31:0] crc_reg, crc_next;
    logic [7:0]  held_reg [4];
    logic [2:0]  count_reg, count_next;
    logic [31:0] crc_fold;
    logic [31:0] rx_word;
    logic [31:0] rx_fill;
    logic        accept;
    logic        full;

    assign cfg_ready = 1'b1;
    assign s_ready   = push_ready;
    assign accept    = s_valid && push_ready;
    assign full      = (count_reg >= HELD_FULL);
    assign rx_word   = {s_in_byte, held_reg[3], held_reg[2], held_reg[1]};
    assign rx_fill   = {s_in_byte, held_reg[2], held_reg[1], held_reg[0]};

    always_comb begin
        crc_fold   = crc_byte(crc_reg, mode_reg ? held_reg[0] : s_in_byte);
        crc_next   = crc_reg;
        count_next = count_reg;
        push_valid = 1'b0;
        push_entry = '{cmd: CMD_PAYLOAD, data: s_in_byte, crc: crc_fold ^ CRC_ONES,
                       ok: 1'b0, short_frame: 1'b0};
        if (!mode_reg) begin
            push_valid = accept;
            crc_next   = crc_fold;
            if (s_in_last) begin
                push_entry.cmd = CMD_PAY_APPEND;
            end
        end else if (full) begin
            push_valid      = accept;
            push_entry.data = held_reg[0];
            crc_next        = crc_fold;
            if (s_in_last) begin
                push_entry.cmd = CMD_PAY_VERDICT;
                push_entry.ok  = (rx_word == (crc_fold ^ CRC_ONES));
            end
        end else begin
            count_next = count_reg + 3'd1;
            if (s_in_last) begin
                push_valid     = accept;
                push_entry.cmd = CMD_VERDICT;
                if (count_next == HELD_FULL) begin
                    push_entry.ok = (rx_fill == (crc_reg ^ CRC_ONES));
                end else begin
                    push_entry.short_frame = 1'b1;
                end
            end
        end
        if (s_in_last) begin
            crc_next   = CRC_ONES;
            count_next = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            crc_reg   <= CRC_ONES;
            count_reg <= 3'd0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_wdata;
            end
            if (accept) begin
                crc_reg   <= crc_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && mode_reg) begin
            if (full) begin
                held_reg[0] <= held_reg[1];
                held_reg[1] <= held_reg[2];
                held_reg[2] <= held_reg[3];
                held_reg[3] <= s_in_byte;
            end else begin
                held_reg[count_reg[1:0]] <= s_in_byte;
            end
        end
    end

endmodule

// File: sv/crc32fac_fifo.sv
// Short queue of entries between the front and the back end.
// Depends on crc32fac_pkg.
module crc32fac_fifo import crc32fac_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   pop_valid,
    input  logic   pop,
    output entry_t pop_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == LAST_PTR) ? '0 : wr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == LAST_PTR) ? '0 : rd_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

endmodule

// File: sv/crc32fac_back.sv
// Back end: expands each queue entry into its result beats and drives the
// output register. Depends on crc32fac_pkg.
module crc32fac_back import crc32fac_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       pop_valid,
    output logic       pop,
    input  entry_t     pop_entry,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_out_kind,
    output logic       m_out_last,
    output logic       m_crc_ok,
    output logic       m_frame_short
);

    logic        valid_reg;
    logic [7:0]  byte_reg, byte_next;
    kind_t       kind_reg, kind_next;
    logic        last_reg, last_next;
    logic        ok_reg, ok_next;
    logic        short_reg, short_next;
    logic [2:0]  step_reg;
    logic        final_beat;
    logic        load;
    logic [1:0]  crc_sel;

    assign load    = pop_valid && (!valid_reg || m_ready);
    assign pop     = load && final_beat;
    assign crc_sel = 2'(step_reg - 3'd1);

    always_comb begin
        byte_next  = pop_entry.data;
        kind_next  = KIND_PAYLOAD;
        last_next  = 1'b0;
        ok_next    = 1'b0;
        short_next = 1'b0;
        final_beat = 1'b0;
        case (pop_entry.cmd)
            CMD_PAYLOAD: begin
                final_beat = 1'b1;
            end
            CMD_PAY_APPEND: begin
                if (step_reg != 3'd0) begin
                    byte_next  = pop_entry.crc[8*crc_sel +: 8];
                    kind_next  = KIND_CRC;
                    final_beat = (step_reg == 3'd4);
                    last_next  = final_beat;
                end
            end
            CMD_PAY_VERDICT: begin
                if (step_reg != 3'd0) begin
                    byte_next  = 8'd0;
                    kind_next  = KIND_VERDICT;
                    ok_next    = pop_entry.ok;
                    final_beat = 1'b1;
                    last_next  = 1'b1;
                end
            end
            default: begin
                byte_next  = 8'd0;
                kind_next  = KIND_VERDICT;
                ok_next    = pop_entry.ok;
                short_next = pop_entry.short_frame;
                final_beat = 1'b1;
                last_next  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= 3'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                step_reg  <= final_beat ? 3'd0 : step_reg + 3'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg  <= byte_next;
            kind_reg  <= kind_next;
            last_reg  <= last_next;
            ok_reg    <= ok_next;
            short_reg <= short_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_out_kind    = kind_reg;
    assign m_out_last    = last_reg;
    assign m_crc_ok      = ok_reg;
    assign m_frame_short = short_reg;

endmodule

// File: sv/crc32_frame_append_check_core.sv
// Top level of the CRC-32 frame append and check core.
// Instantiates crc32fac_front, crc32fac_fifo and crc32fac_back; uses crc32fac_pkg.
//
//   Channel  Direction  Handshake              Beat carries
//   cfg      in         cfg_valid/cfg_ready    cfg_wdata (mode)
//   s        in         s_valid/s_ready        s_in_byte, s_in_last
//   m        out        m_valid/m_ready        m_out_byte, m_out_kind, m_out_last,
//                                              m_crc_ok, m_frame_short
//
// One input beat is taken per cycle while the queue has room. The back end sends
// one result beat per cycle while the result channel is ready, so a frame end
// adds one verdict beat in check mode and four CRC beats in append mode. Reset is
// synchronous and active low and clears the CRC, the delay line count, the queue
// and the output register; the mode resets to append.
// A stalled result channel fills the queue of FIFO_DEPTH entries before s_ready falls.
module crc32_frame_append_check_core import crc32fac_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_out_kind,
    output logic       m_out_last,
    output logic       m_crc_ok,
    output logic       m_frame_short
);

    logic   push_valid, push_ready;
    entry_t push_entry;
    logic   pop_valid, pop;
    entry_t pop_entry;

    crc32fac_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    crc32fac_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_entry  (pop_entry)
    );

    crc32fac_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop           (pop),
        .pop_entry     (pop_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_out_kind    (m_out_kind),
        .m_out_last    (m_out_last),
        .m_crc_ok      (m_crc_ok),
        .m_frame_short (m_frame_short)
    );

endmodule

// File: sv/crc32fac_checker.sv
// Port-level checks for the CRC-32 frame append and check core, and the bind
// that attaches them to the top level. Depends on crc32fac_pkg.
module crc32fac_checker import crc32fac_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       cfg_wdata,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_byte,
    input logic       s_in_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic [1:0] m_out_kind,
    input logic       m_out_last,
    input logic       m_crc_ok,
    input logic       m_frame_short
);

    // A stalled result beat keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_kind)
            && $stable(m_out_last) && $stable(m_crc_ok) && $stable(m_frame_short))
        else $error("stalled result beat changed");

    // Verdict flags appear only on a final verdict beat with a zero byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_crc_ok || m_frame_short) |->
            m_out_kind == KIND_VERDICT && m_out_last && m_out_byte == 8'd0)
        else $error("verdict flag outside a verdict beat");

    // A short frame never passes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_short |-> !m_crc_ok)
        else $error("short frame reported as passing");

    // The appended CRC bytes go out back to back until the last one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_out_kind == KIND_CRC && !m_out_last |=>
            m_valid && m_out_kind == KIND_CRC)
        else $error("appended CRC bytes interrupted");

    // Payload beats never close a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind == KIND_PAYLOAD |-> !m_out_last)
        else $error("payload beat marked last");

endmodule

bind crc32_frame_append_check_core crc32fac_checker u_checker (.*);

// File: verif/tb_crc32_frame_append_check_core.sv
// Self-checking testbench for crc32_frame_append_check_core in append and check modes.
// Drives byte beats and mode writes, predicts every result beat and compares it on arrival.
// Depends on crc32fac_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_crc32_frame_append_check_core;
    import crc32fac_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
        logic       ok;
        logic       short_flag;
    } out_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_wdata = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'd0;
    logic       s_in_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic [1:0] m_out_kind;
    logic       m_out_last;
    logic       m_crc_ok;
    logic       m_frame_short;

    in_beat_t   bytes_to_send [$];
    out_beat_t  beats_awaited [$];

    logic        framer_mode;
    logic [31:0] framer_crc;
    logic [7:0]  held_line [4];
    int          held_n;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic hold_arm = 1'b0;
    int  hold_left = 0;
    int  cycles = 0;
    int  fail_count = 0;
    int  bytes_accepted = 0;
    int  beats_checked = 0;
    int  verdicts_good = 0;
    int  verdicts_short = 0;
    int  mode_writes = 0;

    crc32_frame_append_check_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_kind   (m_out_kind),
        .m_out_last   (m_out_last),
        .m_crc_ok     (m_crc_ok),
        .m_frame_short(m_frame_short)
    );

    always #2 aclk = ~aclk;

    function automatic logic [31:0] crc32_reflect_fold(logic [31:0] acc, logic [7:0] data);
        logic [31:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic out_beat_t make_beat(logic [7:0] data, kind_t kind, logic last,
                                            logic ok, logic short_flag);
        out_beat_t o;
        o.data = data;
        o.kind = kind;
        o.last = last;
        o.ok = ok;
        o.short_flag = short_flag;
        return o;
    endfunction

    function automatic void framer_clear();
        framer_crc = CRC_ONES;
        held_n = 0;
        for (int i = 0; i < 4; i++) begin
            held_line[i] = 8'd0;
        end
    endfunction

    task automatic framer_accept(logic [7:0] data, logic last);
        logic [31:0] fin;
        logic [31:0] rx;
        if (!framer_mode) begin
            framer_crc = crc32_reflect_fold(framer_crc, data);
            beats_awaited.push_back(make_beat(data, KIND_PAYLOAD, 1'b0, 1'b0, 1'b0));
            if (last) begin
                fin = framer_crc ^ CRC_ONES;
                for (int k = 0; k < 4; k++) begin
                    beats_awaited.push_back(make_beat(fin[8*k +: 8], KIND_CRC, k == 3,
                                                      1'b0, 1'b0));
                end
                framer_clear();
            end
        end else begin
            if (held_n >= HELD_FULL) begin
                framer_crc = crc32_reflect_fold(framer_crc, held_line[0]);
                beats_awaited.push_back(make_beat(held_line[0], KIND_PAYLOAD, 1'b0,
                                                  1'b0, 1'b0));
                held_line[0] = held_line[1];
                held_line[1] = held_line[2];
                held_line[2] = held_line[3];
                held_line[3] = data;
            end else begin
                held_line[held_n] = data;
                held_n++;
            end
            if (last) begin
                if (held_n < HELD_FULL) begin
                    beats_awaited.push_back(make_beat(8'd0, KIND_VERDICT, 1'b1, 1'b0, 1'b1));
                end else begin
                    rx = {held_line[3], held_line[2], held_line[1], held_line[0]};
                    beats_awaited.push_back(make_beat(8'd0, KIND_VERDICT, 1'b1,
                                                      rx == (framer_crc ^ CRC_ONES), 1'b0));
                end
                framer_clear();
            end
        end
    endtask

    task automatic flag(string msg);
        $display("MISMATCH at result beat %0d: %s", beats_checked, msg);
        fail_count++;
    endtask

    // Byte driver: holds a beat until it is taken, then offers the next one or idles.
    always @(posedge aclk) begin : drive_p
        in_beat_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                framer_accept(s_in_byte, s_in_last);
                bytes_accepted++;
            end
            if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = bytes_to_send.pop_front();
                s_in_byte <= nxt.data;
                s_in_last <= nxt.last;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : watch_p
        out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (beats_awaited.size() == 0) begin
                    flag("result beat arrived with nothing expected");
                end else begin
                    want = beats_awaited.pop_front();
                    if (m_out_byte !== want.data)
                        flag($sformatf("out_byte %0h, expected %0h", m_out_byte, want.data));
                    if (m_out_kind !== want.kind)
                        flag($sformatf("out_kind %0d, expected %0d", m_out_kind, want.kind));
                    if (m_out_last !== want.last)
                        flag($sformatf("out_last %0b, expected %0b", m_out_last, want.last));
                    if (m_crc_ok !== want.ok)
                        flag($sformatf("crc_ok %0b, expected %0b", m_crc_ok, want.ok));
                    if (m_frame_short !== want.short_flag)
                        flag($sformatf("frame_short %0b, expected %0b", m_frame_short,
                                       want.short_flag));
                    if (want.kind == KIND_VERDICT) begin
                        verdicts_good += want.ok;
                        verdicts_short += want.short_flag;
                    end
                end
                beats_checked++;
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_byte(logic [7:0] data, logic last);
        in_beat_t b;
        b.data = data;
        b.last = last;
        bytes_to_send.push_back(b);
    endtask

    task automatic queue_sealed_frame(int payload_len, logic spoil);
        logic [7:0]  frame [$];
        logic [31:0] acc;
        int          hit;
        acc = CRC_ONES;
        for (int i = 0; i < payload_len; i++) begin
            frame.push_back(8'($urandom_range(255)));
            acc = crc32_reflect_fold(acc, frame[i]);
        end
        acc = acc ^ CRC_ONES;
        for (int k = 0; k < 4; k++) begin
            frame.push_back(acc[8*k +: 8]);
        end
        if (spoil) begin
            hit = $urandom_range(frame.size() - 1);
            frame[hit] = frame[hit] ^ (8'h01 << $urandom_range(7));
        end
        foreach (frame[i]) begin
            queue_byte(frame[i], i == frame.size() - 1);
        end
    endtask

    function automatic int pick_len();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(20, 48);
        end
        return $urandom_range(1, 10);
    endfunction

    task automatic fill_random(logic check, int budget);
        int target;
        int len;
        int pick;
        target = bytes_to_send.size() + budget;
        while (bytes_to_send.size() < target) begin
            pick = $urandom_range(99);
            if (!check) begin
                len = pick_len();
                for (int i = 0; i < len; i++) begin
                    queue_byte(8'($urandom_range(255)), i == len - 1);
                end
            end else if (pick < 70) begin
                queue_sealed_frame(pick_len() - 1, 1'b0);
            end else if (pick < 82) begin
                queue_sealed_frame(pick_len() - 1, 1'b1);
            end else if (pick < 90) begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    queue_byte(8'($urandom_range(255)), i == len - 1);
                end
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    queue_byte(8'($urandom_range(255)), $urandom_range(4) == 0);
                end
            end
        end
    endtask

    task automatic settle();
        do @(negedge aclk);
        while (bytes_to_send.size() != 0 || s_valid || beats_awaited.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_mode(logic m);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= m;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        framer_mode = m;
        mode_writes++;
    endtask

    initial begin
        framer_mode = 1'b0;
        framer_clear();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Append mode straight out of reset, then the check-mode corner cases.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        settle();
        write_mode(1'b1);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h80, 1'b1);
        queue_sealed_frame(0, 1'b0);
        queue_sealed_frame(1, 1'b0);
        queue_sealed_frame(1, 1'b1);
        for (int i = 0; i < 5; i++) begin
            queue_byte(8'($urandom_range(255)), 1'b0);
        end
        settle();
        // The open frame is finished in append mode.
        write_mode(1'b0);
        queue_byte(8'h7E, 1'b1);
        settle();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            write_mode(1'b1);
            fill_random(1'b1, 45);
            settle();
            write_mode(1'b0);
            fill_random(1'b0, 45);
            settle();
        end

        // Long receiver hold-off while bytes keep coming, so the input stalls.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_mode(1'b0);
        @(posedge aclk);
        hold_arm <= 1'b1;
        @(posedge aclk);
        hold_arm <= 1'b0;
        fill_random(1'b0, 24);
        settle();

        if (beats_awaited.size() != 0) begin
            flag($sformatf("%0d expected beats never arrived", beats_awaited.size()));
        end
        $display("Covered %0d input bytes across %0d mode writes and %0d result beats,",
                 bytes_accepted, mode_writes, beats_checked);
        $display("with %0d good and %0d short check verdicts.", verdicts_good, verdicts_short);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/crc32fac_pkg.sv
sv/crc32fac_front.sv
sv/crc32fac_fifo.sv
sv/crc32fac_back.sv
sv/crc32_frame_append_check_core.sv
sv/crc32fac_checker.sv
verif/tb_crc32_frame_append_check_core.sv
